>>> rtl/core/assert_macros.svh
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

>>> rtl/core/eif_pkg.sv
`timescale 1ns / 1ps
package eif_pkg;

	localparam int unsigned NEURONS_DEF = 1024;
	localparam int unsigned REFRACTORY_DEF = 20;
	localparam int unsigned CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DT_OVER_TAU = 3'd0,
		REG_LEAK_V      = 3'd1,
		REG_CRIT_V      = 3'd2,
		REG_SHARP       = 3'd3,
		REG_INV_SHARP   = 3'd4,
		REG_LOWER_BOUND = 3'd5,
		REG_THRESHOLD   = 3'd6,
		REG_RESET_V     = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [9:0]         neuron_index;
		logic signed [15:0] syn_step;
	} in_word_t;

	typedef struct packed {
		logic [9:0]         neuron_out;
		logic               spiked;
		logic signed [15:0] potential;
	} out_word_t;

	typedef struct packed {
		logic [15:0]        dt_over_tau;
		logic signed [15:0] leak_v;
		logic signed [15:0] crit_v;
		logic [14:0]        sharp;
		logic [15:0]        inv_sharp;
		logic signed [15:0] lower_bound;
		logic signed [15:0] threshold;
		logic signed [15:0] reset_v;
	} cfg_t;

	// front-to-back queue entry
	typedef struct packed {
		logic [9:0]         idx;
		logic               in_range;
		logic signed [15:0] syn;
	} job_t;

	function automatic logic [15:0] q24_entry(input logic [63:0] acc);
		logic [63:0] e;
		e = (acc + 64'd32768) >> 16;
		return (e > 64'd65535) ? 16'hFFFF : e[15:0];
	endfunction

	// exp((i-128)/16) in Q8.8, evaluated at elaboration from constant inputs
	function automatic logic [15:0] exp_entry(input int i);
		logic [63:0] acc;
		acc = 64'd1 << 24;
		if (i >= 128) begin
			for (int k = 129; k <= i; k++) begin
				if (acc <= (64'd1 << 32))
					acc = (acc * 64'd17859253 + (64'd1 << 23)) >> 24;
			end
		end else begin
			for (int k = 127; k >= i; k--)
				acc = (acc * 64'd15760736 + (64'd1 << 23)) >> 24;
		end
		return q24_entry(acc);
	endfunction

endpackage

>>> rtl/core/eif_neuron_update.sv
`timescale 1ns / 1ps
// A command passes through the queue, the read stage, 4 math stages and the output register
// before its strobe rises. Throughput one word a cycle while no hazard or clearing pass stalls it.
// A command for a neuron still in the pipeline waits until it clears.
// After reset a clearing pass sweeps the state memories; commands queue
// (two deep) meanwhile. Configuration resets to the documented defaults. The receiver cannot stall.
module eif_neuron_update #(
	parameter int unsigned NEURONS          = eif_pkg::NEURONS_DEF,
	parameter int unsigned REFRACTORY_STEPS = eif_pkg::REFRACTORY_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  eif_pkg::in_word_t    in_word,
	output logic                 busy,
	output logic                 done,
	output eif_pkg::out_word_t   result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data
);
	import eif_pkg::*;

	cfg_t cfg_q;
	assign cfg_ready = 1'b1;

	// register file; every index of the 3-bit port maps to a register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dt_over_tau <= 16'd655;
			cfg_q.leak_v      <= -16'sd17920;
			cfg_q.crit_v      <= -16'sd12800;
			cfg_q.sharp       <= 15'd512;
			cfg_q.inv_sharp   <= 16'd2048;
			cfg_q.lower_bound <= -16'sd25600;
			cfg_q.threshold   <= -16'sd5120;
			cfg_q.reset_v     <= -16'sd17920;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DT_OVER_TAU: cfg_q.dt_over_tau <= cfg_data;
				REG_LEAK_V:      cfg_q.leak_v      <= cfg_data;
				REG_CRIT_V:      cfg_q.crit_v      <= cfg_data;
				REG_SHARP:       cfg_q.sharp       <= cfg_data[14:0];
				REG_INV_SHARP:   cfg_q.inv_sharp   <= cfg_data;
				REG_LOWER_BOUND: cfg_q.lower_bound <= cfg_data;
				REG_THRESHOLD:   cfg_q.threshold   <= cfg_data;
				REG_RESET_V:     cfg_q.reset_v     <= cfg_data;
				default: ;
			endcase
		end
	end

	logic push, full, avail, pop;
	job_t job_in, job_out;

	eif_front #(.NEURONS(NEURONS)) u_front (
		.start(start), .in_word(in_word),
		.busy(busy), .push(push), .job(job_in), .full(full)
	);

	eif_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .din(job_in), .full(full),
		.avail(avail), .pop(pop), .dout(job_out)
	);

	eif_back #(.NEURONS(NEURONS), .REFRACTORY_STEPS(REFRACTORY_STEPS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .avail(avail), .job(job_out),
		.pop(pop), .done(done), .result(result)
	);
endmodule

>>> rtl/core/eif_front.sv
`timescale 1ns / 1ps
// Accepts commands, range-checks the index and queues them.
module eif_front #(
	parameter int unsigned NEURONS = 1024
) (
	input  logic              start,
	input  eif_pkg::in_word_t in_word,
	output logic              busy,
	output logic              push,
	output eif_pkg::job_t     job,
	input  logic              full
);
	import eif_pkg::*;

	assign busy = full;
	assign push = start && !full;

	always_comb begin
		job.idx      = in_word.neuron_index;
		job.in_range = ({22'd0, in_word.neuron_index} < 32'(NEURONS));
		job.syn      = in_word.syn_step;
	end
endmodule

>>> rtl/core/eif_queue.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Two-entry queue between front and back.
module eif_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  eif_pkg::job_t din,
	output logic          full,
	output logic          avail,
	input  logic          pop,
	output eif_pkg::job_t dout
);
	import eif_pkg::*;

	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign avail = (cnt_q != 2'd0);
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && full, "queue overflow")
	`ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && !avail, "queue underflow")
	`ASSERT_NEVER(a_cnt_range, clk, arst_n, cnt_q == 2'd3, "queue count out of range")
endmodule

>>> rtl/core/eif_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Update pipeline: s1 state read, s2 exponent, s3 table index, s4 drive,
// s5 product, sum and write-back. State is forwarded from s5 to s1 for hazards.
module eif_back #(
	parameter int unsigned NEURONS          = 1024,
	parameter int unsigned REFRACTORY_STEPS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  eif_pkg::cfg_t      cfg,
	input  logic               avail,
	input  eif_pkg::job_t      job,
	output logic               pop,
	output logic               done,
	output eif_pkg::out_word_t result
);
	import eif_pkg::*;

	localparam int unsigned AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
	localparam int unsigned CLR_W = AW + 1;

	logic [15:0] exp_rom [256];
	always_comb begin
		for (int i = 0; i < 256; i++) exp_rom[i] = exp_entry(i);
	end

	logic signed [15:0] vmem [NEURONS];
	logic [7:0]         cmem [NEURONS];

	// clearing pass after reset
	logic [CLR_W-1:0] clr_q;
	logic             clearing;
	assign clearing = (clr_q != CLR_W'(NEURONS));

	logic [AW-1:0] addr;
	assign addr = AW'(job.idx);

	// s1: memory read
	logic               v_s1, rng_s1;
	logic [9:0]         idx_s1;
	logic signed [15:0] syn_s1, vrd_s1;
	logic [7:0]         crd_s1;

	// write-back from s5
	logic               we_s5;
	logic [AW-1:0]      wa_s5;
	logic signed [15:0] wv_s5;
	logic [7:0]         wc_s5;

	always_ff @(posedge clk) begin
		if (clearing) begin
			vmem[clr_q[AW-1:0]] <= 16'sd0;
			cmem[clr_q[AW-1:0]] <= 8'hFF;
		end else if (we_s5) begin
			vmem[wa_s5] <= wv_s5;
			cmem[wa_s5] <= wc_s5;
		end
	end

	always_ff @(posedge clk) begin
		vrd_s1 <= vmem[addr];
		crd_s1 <= cmem[addr];
		idx_s1 <= job.idx;
		syn_s1 <= job.syn;
		rng_s1 <= job.in_range;
	end

	// later-stage copies for forwarding
	logic               v_s2, v_s3, v_s4, v_s5;
	logic [9:0]         idx_s2, idx_s3, idx_s4, idx_s5;
	logic               rng_s2, rng_s3, rng_s4, rng_s5;
	logic               act_s2, act_s3, act_s4, act_s5;
	logic signed [15:0] syn_s2, syn_s3, syn_s4, syn_s5;
	logic signed [15:0] v_s2v, v_s3v, v_s4v, v_s5v;
	logic [7:0]         c_s2, c_s3, c_s4, c_s5;

	// A neuron may be in flight in s1..s5; the stored value is then stale.
	// Same neuron cannot be resolved by forwarding from s5 alone unless
	// repeats stall: we stall pop while the index is in s1..s4.
	logic hazard;
	always_comb begin
		hazard = 1'b0;
		if (v_s1 && idx_s1 == job.idx) hazard = 1'b1;
		if (v_s2 && idx_s2 == job.idx) hazard = 1'b1;
		if (v_s3 && idx_s3 == job.idx) hazard = 1'b1;
		if (v_s4 && idx_s4 == job.idx) hazard = 1'b1;
	end

	// a stalled word stays in the queue
	assign pop = avail && !clearing && !hazard;

	logic go;
	assign go = pop;

	// effective state at s1 with forwarding from s5 write-back
	logic signed [15:0] vcur;
	logic [7:0]         ccur;
	logic               fwd_q;
	logic signed [15:0] fv_q;
	logic [7:0]         fc_q;
	always_comb begin
		vcur = fwd_q ? fv_q : vrd_s1;
		ccur = fwd_q ? fc_q : crd_s1;
	end

	// s2: exponent product
	logic signed [33:0] e_s2;
	// s3: table index, x, refractory bypass
	logic [7:0]         ti_s3;
	logic [15:0]        ex_s3;
	// s4: drive
	logic signed [24:0] drive_s4;
	// s5: dv
	logic signed [41:0] prod_s5;

	always_comb begin
		ex_s3 = exp_rom[ti_s3];
	end
	logic [30:0] sx_full;
	assign sx_full = {16'd0, cfg.sharp} * {15'd0, ex_s3};

	logic signed [41:0] prod_c;
	assign prod_c = 42'(drive_s4) * $signed({26'd0, cfg.dt_over_tau});

	always_ff @(posedge clk) begin
		v_s2v  <= vcur;   c_s2 <= ccur;
		idx_s2 <= idx_s1; syn_s2 <= syn_s1; rng_s2 <= rng_s1;
		act_s2 <= rng_s1 && (ccur > 8'(REFRACTORY_STEPS));
		e_s2   <= 34'(33'(vcur) - 33'(cfg.crit_v)) * $signed({18'd0, cfg.inv_sharp});

		v_s3v  <= v_s2v; c_s3 <= c_s2;
		idx_s3 <= idx_s2; syn_s3 <= syn_s2; rng_s3 <= rng_s2; act_s3 <= act_s2;
		if (e_s2 >>> 16 < -34'sd128)      ti_s3 <= 8'd0;
		else if (e_s2 >>> 16 > 34'sd127)  ti_s3 <= 8'd255;
		else                              ti_s3 <= 8'(e_s2[23:16] + 8'd128);

		v_s4v  <= v_s3v; c_s4 <= c_s3;
		idx_s4 <= idx_s3; syn_s4 <= syn_s3; rng_s4 <= rng_s3; act_s4 <= act_s3;
		drive_s4 <= 25'(cfg.leak_v) - 25'(v_s3v) + $signed({2'b0, sx_full[30:8]});

		v_s5v  <= v_s4v; c_s5 <= c_s4;
		idx_s5 <= idx_s4; syn_s5 <= syn_s4; rng_s5 <= rng_s4; act_s5 <= act_s4;
		prod_s5 <= prod_c;
	end

	// s5 combinational finish
	logic signed [26:0] dv, vn;
	logic signed [15:0] vsat, vout;
	logic               spk;
	logic [7:0]         cinc;
	always_comb begin
		dv   = 27'((prod_s5 + 42'sd32768) >>> 16);
		vn   = 27'(v_s5v) + dv + 27'(syn_s5);
		if (vn > 27'sd32767)       vsat = 16'sh7FFF;
		else if (vn < -27'sd32768) vsat = 16'sh8000;
		else                       vsat = vn[15:0];
		if (vsat < cfg.lower_bound) vsat = cfg.lower_bound;
		cinc = (c_s5 == 8'hFF) ? 8'hFF : c_s5 + 8'd1;
		spk  = act_s5 && (vsat > cfg.threshold);
		vout = !rng_s5 ? 16'sd0 : !act_s5 ? v_s5v : spk ? cfg.reset_v : vsat;
		we_s5 = v_s5 && rng_s5;
		wa_s5 = AW'(idx_s5);
		wv_s5 = vout;
		wc_s5 = spk ? 8'd0 : cinc;
	end

	always_ff @(posedge clk) begin
		fv_q <= wv_s5;
		fc_q <= wc_s5;
		result.neuron_out <= idx_s5;
		result.spiked     <= spk;
		result.potential  <= vout;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			fwd_q <= 1'b0; done <= 1'b0;
		end else begin
			if (clearing) clr_q <= clr_q + 1'b1;
			v_s1 <= go;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4;
			// s5 write lands the same edge that the next read samples
			fwd_q <= we_s5 && go && (wa_s5 == addr);
			done  <= v_s5;
		end
	end

	`ASSERT_NEVER(a_no_go_clear, clk, arst_n, go && clearing, "issue during clear")
	`ASSERT_CLK(a_done_follows, clk, arst_n, v_s5 |=> done, "result lost")
	`ASSERT_NEVER(a_no_write_clear, clk, arst_n, we_s5 && clearing, "write during clear")
endmodule

>>> bench/eif_neuron_update_test.sv
`timescale 1ns / 1ps
module eif_neuron_update_test;
	import eif_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE = 12;  // pipeline depth plus a margin

	// Tracks the neuron population and predicts every update word.
	class neuron_tracker;
		logic signed [15:0] membrane[NEURONS_DEF];
		logic [7:0]         since_spike[NEURONS_DEF];
		logic [15:0]        exp_lut[256];
		cfg_t               cfg;
		out_word_t          pending[$];
		int                 mismatches;

		function new();
			longint unsigned acc;
			for (int i = 0; i < NEURONS_DEF; i++) begin
				membrane[i] = '0;
				since_spike[i] = 8'hFF;
			end
			cfg.dt_over_tau = 16'd655;
			cfg.leak_v      = -16'sd17920;
			cfg.crit_v      = -16'sd12800;
			cfg.sharp       = 15'd512;
			cfg.inv_sharp   = 16'd2048;
			cfg.lower_bound = -16'sd25600;
			cfg.threshold   = -16'sd5120;
			cfg.reset_v     = -16'sd17920;
			mismatches = 0;
			// Q8.24 accumulator stepped by exp(+-1/16), rounded to Q8.8, capped
			acc = 64'd1 << 24;
			exp_lut[128] = to_q88(acc);
			for (int i = 129; i < 256; i++) begin
				if (acc <= (64'd1 << 32))
					acc = (acc * 64'd17859253 + (64'd1 << 23)) >> 24;
				exp_lut[i] = to_q88(acc);
			end
			acc = 64'd1 << 24;
			for (int i = 127; i >= 0; i--) begin
				acc = (acc * 64'd15760736 + (64'd1 << 23)) >> 24;
				exp_lut[i] = to_q88(acc);
			end
		endfunction

		function logic [15:0] to_q88(longint unsigned acc);
			longint unsigned e;
			e = (acc + 64'd32768) >> 16;
			return (e > 64'd65535) ? 16'hFFFF : e[15:0];
		endfunction

		function void write_reg(cfg_reg_t idx, logic [15:0] data);
			case (idx)
				REG_DT_OVER_TAU: cfg.dt_over_tau = data;
				REG_LEAK_V:      cfg.leak_v = data;
				REG_CRIT_V:      cfg.crit_v = data;
				REG_SHARP:       cfg.sharp = data[14:0];
				REG_INV_SHARP:   cfg.inv_sharp = data;
				REG_LOWER_BOUND: cfg.lower_bound = data;
				REG_THRESHOLD:   cfg.threshold = data;
				REG_RESET_V:     cfg.reset_v = data;
				default: ;
			endcase
		endfunction

		// One timestep of one neuron; queues the expected update word.
		function void note_update(in_word_t w);
			out_word_t r;
			longint v, e, ti, x, drive, dv;
			logic [7:0] cnt;
			r.neuron_out = w.neuron_index;
			r.spiked = 1'b0;
			r.potential = '0;
			if (w.neuron_index < NEURONS_DEF) begin
				v = membrane[w.neuron_index];
				cnt = since_spike[w.neuron_index];
				if (cnt <= REFRACTORY_DEF) begin
					// refractory: hold potential, count on
					if (cnt != 8'hFF) cnt++;
					r.potential = v[15:0];
				end else begin
					e = (v - longint'(cfg.crit_v)) * longint'(cfg.inv_sharp);
					ti = e >>> 16;
					if (ti < -128) ti = -128;
					if (ti > 127) ti = 127;
					x = (longint'(cfg.sharp) * longint'(exp_lut[8'(ti + 128)])) >>> 8;
					drive = longint'(cfg.leak_v) - v + x;
					dv = (drive * longint'(cfg.dt_over_tau) + 32768) >>> 16;
					v = v + dv + longint'(w.syn_step);
					if (v > 32767) v = 32767;
					if (v < -32768) v = -32768;
					if (v < longint'(cfg.lower_bound)) v = cfg.lower_bound;
					if (v > longint'(cfg.threshold)) begin
						r.spiked = 1'b1;
						v = cfg.reset_v;
						cnt = '0;
					end else if (cnt != 8'hFF) begin
						cnt++;
					end
					membrane[w.neuron_index] = v[15:0];
					r.potential = v[15:0];
				end
				since_spike[w.neuron_index] = cnt;
			end
			pending.insert(pending.size(), r);
		endfunction

		function void check_update(out_word_t got);
			out_word_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected update word: neuron %0d spiked %0b potential %0d",
						got.neuron_out, got.spiked, got.potential);
				return;
			end
			want = pending.pop_front();
			if (got.neuron_out !== want.neuron_out || got.spiked !== want.spiked ||
					got.potential !== want.potential) begin
				mismatches++;
				if (mismatches <= 10)
					$display("update mismatch: want n%0d s%0b v%0d, got n%0d s%0b v%0d",
						want.neuron_out, want.spiked, want.potential,
						got.neuron_out, got.spiked, got.potential);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	in_word_t    in_word;
	logic        busy;
	logic        done;
	out_word_t   result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	neuron_tracker tracker;
	int          cycles;

	eif_neuron_update dut (
		.clk(clk), .arst_n(arst_n), .start(start), .in_word(in_word), .busy(busy),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Update words are on the port for one cycle only; take each at its closing edge.
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_update(result);
	end

	// Watchdog: a stuck pipeline or a lost word ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("eif_neuron_update regression: fail");
			$finish;
		end
	end

	// Hold the command until the block takes it; start stays high afterwards
	// so back-to-back words go in without a gap.
	task automatic issue(logic [9:0] idx, logic [15:0] syn);
		in_word_t w;
		w.neuron_index = idx;
		w.syn_step = syn;
		start = 1'b1;
		in_word = w;
		do @(posedge clk); while (busy);
		tracker.note_update(w);
		@(negedge clk);
	endtask

	task automatic pause(int n);
		start = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	// Everything out, then let the pipeline run dry before touching registers.
	task automatic drain();
		pause(1);
		while (tracker.pending.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_cfg(cfg_reg_t idx, logic [15:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic write_all(logic [15:0] dt, logic [15:0] leak, logic [15:0] crit,
			logic [15:0] shp, logic [15:0] inv, logic [15:0] lo, logic [15:0] th,
			logic [15:0] rv);
		write_cfg(REG_DT_OVER_TAU, dt);
		write_cfg(REG_LEAK_V, leak);
		write_cfg(REG_CRIT_V, crit);
		write_cfg(REG_SHARP, shp);
		write_cfg(REG_INV_SHARP, inv);
		write_cfg(REG_LOWER_BOUND, lo);
		write_cfg(REG_THRESHOLD, th);
		write_cfg(REG_RESET_V, rv);
	endtask

	// Bursts of commands; most go to a handful of neurons so that they climb
	// to threshold, spike and sit out the refractory steps.
	task automatic random_burst(int count);
		int left;
		int burst;
		logic [9:0]  idx;
		logic [15:0] syn;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			for (int k = 0; k < burst && left > 0; k++) begin
				case ($urandom_range(0, 9))
					0, 1:    idx = 10'($urandom);
					default: idx = 10'($urandom_range(0, 7));
				endcase
				case ($urandom_range(0, 5))
					0:       syn = 16'($urandom);
					1:       syn = 16'($urandom_range(0, 4096));
					default: syn = 16'($urandom_range(0, 1024) - 256);
				endcase
				issue(idx, syn);
				left--;
			end
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 9));
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		in_word = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cycles = 0;
		tracker = new();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: documented defaults, extremes of the inputs, spike then refractory hold
		write_all(16'd655, -16'sd17920, -16'sd12800, 16'd512, 16'd2048, -16'sd25600,
			-16'sd5120, -16'sd17920);
		issue(10'd0, 16'd0);
		issue(10'd1023, 16'h8000);
		issue(10'd1, 16'h7FFF);      // jumps past threshold
		issue(10'd1, 16'h7FFF);      // refractory: no change
		issue(10'd1, 16'h0000);
		issue(10'd2, 16'h8000);      // clamped at lower bound
		issue(10'd2, 16'hFFFF);
		issue(10'd512, 16'h5555);
		issue(10'd341, 16'hAAAA);
		issue(10'd1023, 16'h7FFF);
		pause(3);
		repeat (22) issue(10'd1, 16'd0);   // sit out the refractory steps
		drain();

		// extremes of every register, exponent clamped high and low
		write_all(16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000,
			16'h7FFF, 16'h0000);
		issue(10'd3, 16'h7FFF);
		issue(10'd4, 16'h8000);
		random_burst(60);
		drain();

		// zero slope and reciprocal, zero step, threshold at the bottom
		write_all(16'h0000, 16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF,
			16'h8000, 16'h8000);
		issue(10'd5, 16'h0000);
		issue(10'd6, 16'h8000);
		random_burst(40);
		drain();

		// back to realistic values
		write_all(16'd655, -16'sd17920, -16'sd12800, 16'd512, 16'd2048, -16'sd25600,
			-16'sd5120, -16'sd17920);
		random_burst(150);
		drain();

		// random register settings
		for (int p = 0; p < 4; p++) begin
			write_all(16'($urandom), 16'($urandom_range(0, 20000) - 22000),
				16'($urandom_range(0, 20000) - 20000), 16'($urandom_range(0, 32767)),
				16'($urandom), 16'($urandom_range(0, 65535)),
				16'($urandom_range(0, 12000) - 12000), 16'($urandom));
			random_burst(45);
			drain();
		end

		repeat (SETTLE) @(negedge clk);
		if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
			$display("eif_neuron_update regression: pass");
		end else begin
			$display("eif_neuron_update regression: fail");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/eif_pkg.sv
rtl/core/eif_front.sv
rtl/core/eif_queue.sv
rtl/core/eif_back.sv
rtl/core/eif_neuron_update.sv
bench/eif_neuron_update_test.sv
